// ===== design/lfsr_dec_pkg.sv =====
// shared constants and types for the pseudo-random counter decoder
package lfsr_dec_pkg;

  // width of the linear count and of the raw reading
  localparam int unsigned CNT_W = 14;
  // decode word: present flag over the linear count
  localparam int unsigned WORD_W = CNT_W + 1;

  // default configuration of the counter
  localparam int unsigned DEF_MAX_COUNT    = 11811;
  localparam int unsigned DEF_COUNTER_BITS = 14;

  // status from the table builder to the top level
  typedef struct packed {
    logic wr_en;
    logic ready;
  } init_status_t;

endpackage

// ===== design/lfsr_counter_decoder.sv =====
// top level of the pseudo-random counter decoder
//
//  channel  | ports                          | handshake
//  ---------+--------------------------------+-------------------------------
//  input    | in_raw_reading                 | start high while busy low
//  result   | out_count, out_found           | out_valid high with each result
//
// after reset the block clears the table and then walks the shift register,
// with busy high. it then takes one request per cycle; each result appears
// on the cycle after its request, set by the single read port of the table.
// reset is synchronous and restarts the build; the receiver cannot stall.
module lfsr_counter_decoder
  import lfsr_dec_pkg::*;
#(
  parameter int unsigned MAX_COUNT    = DEF_MAX_COUNT,
  parameter int unsigned COUNTER_BITS = DEF_COUNTER_BITS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [CNT_W-1:0] in_raw_reading,
  output logic             out_valid,
  output logic [CNT_W-1:0] out_count,
  output logic             out_found
);

  init_status_t            init_st;
  logic [COUNTER_BITS-1:0] wr_addr;
  logic [WORD_W-1:0]       wr_data;
  logic [WORD_W-1:0]       rd_data;
  logic [COUNTER_BITS+CNT_W-1:0] reading_ext;
  logic [COUNTER_BITS-1:0] key;
  logic                    accept;
  logic                    valid_r;
  logic                    zero_r;
  logic                    hit;

  // table builder
  lfsr_dec_init #(
    .MAX_COUNT    (MAX_COUNT),
    .COUNTER_BITS (COUNTER_BITS)
  ) u_init (
    .clk     (clk),
    .rst_n   (rst_n),
    .status  (init_st),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // request key: low counter bits of the reading
  assign reading_ext = {{COUNTER_BITS{1'b0}}, in_raw_reading};
  assign key         = reading_ext[COUNTER_BITS-1:0];
  assign busy        = !init_st.ready;
  assign accept      = start && init_st.ready;

  // decode table
  lfsr_dec_mem #(
    .ADDR_W (COUNTER_BITS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (init_st.wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (accept),
    .rd_addr (key),
    .rd_data (rd_data)
  );

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= accept;
    end
  end

  // zero reading flag travels with the read
  always_ff @(posedge clk) begin
    if (accept) begin
      zero_r <= (key == '0);
    end
  end

  // result drive
  assign hit       = valid_r && rd_data[WORD_W-1] && !zero_r;
  assign out_valid = valid_r;
  assign out_found = hit;
  assign out_count = hit ? rd_data[CNT_W-1:0] : '0;

endmodule

// ===== design/lfsr_dec_mem.sv =====
// decode table memory: one write port, one registered read port
module lfsr_dec_mem
  import lfsr_dec_pkg::*;
#(
  parameter int unsigned ADDR_W = DEF_COUNTER_BITS
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WORD_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WORD_W-1:0] rd_data
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered and enabled by rd_en
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== design/lfsr_dec_init.sv =====
// table builder: clearing pass, then shift register walk writing the decode table
module lfsr_dec_init
  import lfsr_dec_pkg::*;
#(
  parameter int unsigned MAX_COUNT    = DEF_MAX_COUNT,
  parameter int unsigned COUNTER_BITS = DEF_COUNTER_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  output init_status_t            status,
  output logic [COUNTER_BITS-1:0] wr_addr,
  output logic [WORD_W-1:0]       wr_data
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_BUILD = 2'd1;
  localparam logic [1:0] ST_DONE  = 2'd2;

  localparam logic [CNT_W-1:0]        LAST_STEP  = CNT_W'(MAX_COUNT - 1);
  localparam logic [COUNTER_BITS-1:0] LAST_ENTRY = {COUNTER_BITS{1'b1}};

  logic [1:0]              state_r, state_nxt;
  logic [COUNTER_BITS-1:0] clr_addr_r, clr_addr_nxt;
  logic [COUNTER_BITS-1:0] shift_r, shift_nxt;
  logic [CNT_W-1:0]        step_r, step_nxt;
  logic [COUNTER_BITS-1:0] key;
  logic                    fb;

  // bit-reversed shift register value is the table key
  always_comb begin
    for (int i = 0; i < COUNTER_BITS; i++) begin
      key[i] = shift_r[COUNTER_BITS-1-i];
    end
  end

  assign fb = shift_r[COUNTER_BITS-1] ^ shift_r[0];

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    shift_nxt    = shift_r;
    step_nxt     = step_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ENTRY) begin
          state_nxt = ST_BUILD;
        end
      end
      ST_BUILD: begin
        shift_nxt = {shift_r[COUNTER_BITS-2:0], fb};
        step_nxt  = step_r + 1'b1;
        if (step_r == LAST_STEP) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      shift_r    <= '1;
      step_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      shift_r    <= shift_nxt;
      step_r     <= step_nxt;
    end
  end

  // write port drive
  assign status.wr_en = (state_r == ST_CLEAR) || (state_r == ST_BUILD);
  assign status.ready = (state_r == ST_DONE);
  assign wr_addr      = (state_r == ST_BUILD) ? key : clr_addr_r;
  assign wr_data      = (state_r == ST_BUILD) ? {1'b1, step_r} : '0;

endmodule
